@@ rtl/assert_macros.svh @@
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/vai_pkg.sv @@
// types, constants and the arctangent table for the viewing angle pipeline
package vai_pkg;

   // cordic datapath: scaled inputs stay below 2^56, gained results below 2^59
   localparam int DATA_W   = 61;
   // angle accumulator in units of 2^-16 tenth of a degree
   localparam int ANGLE_W  = 30;
   localparam int ANG_FRAC = 16;
   // scaled differences sit at this magnitude whatever the coordinate width
   localparam int SCALE_TOP = 56;

   localparam int AZ_W  = 12;
   localparam int INC_W = 11;
   localparam int RSP_W = 24;

   localparam logic signed [ANGLE_W-1:0] ANG_HALF     = 30'sd32768;
   localparam logic signed [ANGLE_W-1:0] AZ_HALF_TURN = 30'sd117964800;
   localparam logic signed [ANGLE_W-1:0] AZ_FULL_TURN = 30'sd235929600;

   localparam logic [AZ_W-1:0] AZ_WRAP          = 12'd3600;
   localparam logic [AZ_W-1:0] AZ_QUARTER       = 12'd900;
   localparam logic [AZ_W-1:0] AZ_HALF          = 12'd1800;
   localparam logic [AZ_W-1:0] AZ_THREE_QUARTER = 12'd2700;

   localparam logic [INC_W-1:0] INC_LIMIT = 11'd900;

   typedef struct packed {
      logic signed [DATA_W-1:0]  x;
      logic signed [DATA_W-1:0]  y;
      logic signed [ANGLE_W-1:0] z;
   } vec_type;

   typedef struct packed {
      logic flat_zero;
      logic dx_zero;
      logic dy_zero;
      logic dx_neg;
      logic dy_pos;
      logic dz_zero;
      logic dz_pos;
   } side_type;

   typedef struct packed {
      side_type        flags;
      logic [AZ_W-1:0] az;
   } mid_type;

   // round(atan(2^-i)) in accumulator units
   function automatic logic signed [ANGLE_W-1:0] atan_step(input int stage);
      logic signed [ANGLE_W-1:0] angle;
      case (stage)
         0:       angle = 30'sd29491200;
         1:       angle = 30'sd17409672;
         2:       angle = 30'sd9198793;
         3:       angle = 30'sd4669451;
         4:       angle = 30'sd2343786;
         5:       angle = 30'sd1173036;
         6:       angle = 30'sd586661;
         7:       angle = 30'sd293348;
         8:       angle = 30'sd146676;
         9:       angle = 30'sd73339;
         10:      angle = 30'sd36669;
         11:      angle = 30'sd18335;
         12:      angle = 30'sd9167;
         13:      angle = 30'sd4584;
         14:      angle = 30'sd2292;
         15:      angle = 30'sd1146;
         16:      angle = 30'sd573;
         17:      angle = 30'sd286;
         18:      angle = 30'sd143;
         19:      angle = 30'sd72;
         20:      angle = 30'sd36;
         21:      angle = 30'sd18;
         22:      angle = 30'sd9;
         23:      angle = 30'sd4;
         default: angle = '0;
      endcase
      return angle;
   endfunction

endpackage

@@ rtl/vai_cordic_cell.sv @@
// one vectoring cordic micro-rotation with its output register
module vai_cordic_cell #(
   parameter int STAGE = 0
) (
   input  logic             clock,
   input  logic             advance,
   input  vai_pkg::vec_type vec_i,
   output vai_pkg::vec_type vec_o
);

   localparam logic signed [vai_pkg::ANGLE_W-1:0] STEP_ANGLE = vai_pkg::atan_step(STAGE);

   vai_pkg::vec_type vec_ff;
   vai_pkg::vec_type vec_in;
   logic signed [vai_pkg::DATA_W-1:0] x_shift;
   logic signed [vai_pkg::DATA_W-1:0] y_shift;

   // arithmetic shift rounds toward minus infinity
   always_comb begin
      x_shift = $signed(vec_i.x) >>> STAGE;
      y_shift = $signed(vec_i.y) >>> STAGE;
      if (!vec_i.y[vai_pkg::DATA_W-1]) begin
         vec_in.x = $signed(vec_i.x) + y_shift;
         vec_in.y = $signed(vec_i.y) - x_shift;
         vec_in.z = $signed(vec_i.z) + STEP_ANGLE;
      end else begin
         vec_in.x = $signed(vec_i.x) - y_shift;
         vec_in.y = $signed(vec_i.y) + x_shift;
         vec_in.z = $signed(vec_i.z) - STEP_ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         vec_ff <= vec_in;
      end
   end

   assign vec_o = vec_ff;

endmodule

@@ rtl/view_azimuth_inclination.sv @@
// top level: azimuth and inclination of the eye-to-target vector
// an accepted transaction reaches rsp_tvalid through one prep stage, two chains of
// ANGLE_STAGES cordic cells in series and one output register
// throughput is one transaction per cycle; the whole pipe holds while the output waits
// synchronous reset clears only the stage valid bits and the output valid
`include "assert_macros.svh"

module view_azimuth_inclination #(
   parameter int COORD_BITS   = 24,
   parameter int ANGLE_STAGES = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // eye_x, eye_y, eye_z, target_x, target_y, target_z from bit 0 up, zero padded
   input  logic [((6*COORD_BITS+7)/8)*8-1:0]       req_tdata,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // azimuth_tenths [11:0], inclination_tenths [22:12], bit 23 zero
   output logic [vai_pkg::RSP_W-1:0]               rsp_tdata
);

   localparam int DATA_W   = vai_pkg::DATA_W;
   localparam int ANGLE_W  = vai_pkg::ANGLE_W;
   localparam int ANG_FRAC = vai_pkg::ANG_FRAC;
   localparam int AZ_W     = vai_pkg::AZ_W;
   localparam int INC_W    = vai_pkg::INC_W;
   localparam int SCALE_SH = vai_pkg::SCALE_TOP - COORD_BITS;
   localparam int EXT_W    = DATA_W - COORD_BITS - 1;
   localparam int WHOLE_W  = ANGLE_W - ANG_FRAC;
   // prep stage, then the azimuth chain, then the inclination chain
   localparam int PIPE_LEN = 2*ANGLE_STAGES + 1;

   // pipe moves as one whenever the output register can take a result
   logic advance;

   // input fields
   logic signed [COORD_BITS-1:0] eye_x, eye_y, eye_z;
   logic signed [COORD_BITS-1:0] target_x, target_y, target_z;
   logic signed [COORD_BITS:0]   dx, dy, dz;
   logic signed [DATA_W-1:0]     dx_ext, dy_ext, dz_ext;

   // prep stage
   vai_pkg::vec_type  prep_az_ff, prep_az_in;
   vai_pkg::vec_type  prep_dz_ff, prep_dz_in;
   vai_pkg::side_type side_in;
   vai_pkg::side_type side_ff [0:ANGLE_STAGES];

   // stage valid bits
   logic [PIPE_LEN-1:0] valid_ff, valid_in;

   // cell chains; index 0 feeds the first cell
   vai_pkg::vec_type az_vec [0:ANGLE_STAGES];
   vai_pkg::vec_type dz_vec [0:ANGLE_STAGES];
   vai_pkg::vec_type el_vec [0:ANGLE_STAGES];

   // azimuth finish, carried beside the inclination chain
   vai_pkg::mid_type mid_in;
   vai_pkg::mid_type mid_ff [0:ANGLE_STAGES-1];
   logic signed [ANGLE_W-1:0] az_turn, az_pos, az_round;
   logic [AZ_W-1:0]           az_raw, az_wrapped;

   // inclination finish
   logic signed [ANGLE_W-1:0] el_pos, el_round;
   logic [WHOLE_W-1:0]        el_whole;
   logic [INC_W-1:0]          inc_mag, inc_sel;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [AZ_W-1:0]   az_out_ff, az_out_in;
   logic [INC_W-1:0]  inc_out_ff, inc_out_in;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   // unpack and form the difference vector
   assign eye_x    = req_tdata[0*COORD_BITS +: COORD_BITS];
   assign eye_y    = req_tdata[1*COORD_BITS +: COORD_BITS];
   assign eye_z    = req_tdata[2*COORD_BITS +: COORD_BITS];
   assign target_x = req_tdata[3*COORD_BITS +: COORD_BITS];
   assign target_y = req_tdata[4*COORD_BITS +: COORD_BITS];
   assign target_z = req_tdata[5*COORD_BITS +: COORD_BITS];

   assign dx = {target_x[COORD_BITS-1], target_x} - {eye_x[COORD_BITS-1], eye_x};
   assign dy = {target_y[COORD_BITS-1], target_y} - {eye_y[COORD_BITS-1], eye_y};
   assign dz = {target_z[COORD_BITS-1], target_z} - {eye_z[COORD_BITS-1], eye_z};

   assign dx_ext = {{EXT_W{dx[COORD_BITS]}}, dx};
   assign dy_ext = {{EXT_W{dy[COORD_BITS]}}, dy};
   assign dz_ext = {{EXT_W{dz[COORD_BITS]}}, dz};

   always_comb begin
      side_in.dx_zero   = (dx == '0);
      side_in.dy_zero   = (dy == '0);
      side_in.dz_zero   = (dz == '0);
      side_in.flat_zero = side_in.dx_zero && side_in.dy_zero;
      side_in.dx_neg    = dx[COORD_BITS];
      side_in.dy_pos    = !dy[COORD_BITS] && !side_in.dy_zero;
      side_in.dz_pos    = !dz[COORD_BITS] && !side_in.dz_zero;

      // fold into the right half plane; the fold's 180 degrees come back later
      if (dx[COORD_BITS]) begin
         prep_az_in.x = (-dx_ext) <<< SCALE_SH;
         prep_az_in.y = (-dy_ext) <<< SCALE_SH;
      end else begin
         prep_az_in.x = dx_ext <<< SCALE_SH;
         prep_az_in.y = dy_ext <<< SCALE_SH;
      end
      prep_az_in.z = '0;

      // |dz| runs through a matching chain so it picks up the same gain
      if (dz[COORD_BITS]) begin
         prep_dz_in.x = (-dz_ext) <<< SCALE_SH;
      end else begin
         prep_dz_in.x = dz_ext <<< SCALE_SH;
      end
      prep_dz_in.y = '0;
      prep_dz_in.z = '0;
   end

   assign az_vec[0] = prep_az_ff;
   assign dz_vec[0] = prep_dz_ff;

   // second chain: atan2 of gained |dz| over the gained horizontal length
   always_comb begin
      el_vec[0].x = az_vec[ANGLE_STAGES].x;
      el_vec[0].y = dz_vec[ANGLE_STAGES].x;
      el_vec[0].z = '0;
   end

   for (genvar g = 0; g < ANGLE_STAGES; g++) begin : g_cells
      vai_cordic_cell #(
         .STAGE (g)
      ) u_az_cell (
         .clock   (clock),
         .advance (advance),
         .vec_i   (az_vec[g]),
         .vec_o   (az_vec[g+1])
      );

      vai_cordic_cell #(
         .STAGE (g)
      ) u_dz_cell (
         .clock   (clock),
         .advance (advance),
         .vec_i   (dz_vec[g]),
         .vec_o   (dz_vec[g+1])
      );

      vai_cordic_cell #(
         .STAGE (g)
      ) u_el_cell (
         .clock   (clock),
         .advance (advance),
         .vec_i   (el_vec[g]),
         .vec_o   (el_vec[g+1])
      );
   end

   // azimuth: restore the fold, make it positive, round half up, wrap 3600
   always_comb begin
      az_turn  = az_vec[ANGLE_STAGES].z
               + (side_ff[ANGLE_STAGES].dx_neg ? vai_pkg::AZ_HALF_TURN : '0);
      az_pos   = az_turn[ANGLE_W-1] ? az_turn + vai_pkg::AZ_FULL_TURN : az_turn;
      az_round = az_pos + vai_pkg::ANG_HALF;
      az_raw   = az_round[ANG_FRAC +: AZ_W];
      az_wrapped = (az_raw >= vai_pkg::AZ_WRAP) ? az_raw - vai_pkg::AZ_WRAP : az_raw;

      mid_in.flags = side_ff[ANGLE_STAGES];
      // axis-aligned vectors get exact angles
      if (side_ff[ANGLE_STAGES].flat_zero) begin
         mid_in.az = '0;
      end else if (side_ff[ANGLE_STAGES].dx_zero) begin
         mid_in.az = side_ff[ANGLE_STAGES].dy_pos ? vai_pkg::AZ_QUARTER
                                                  : vai_pkg::AZ_THREE_QUARTER;
      end else if (side_ff[ANGLE_STAGES].dy_zero) begin
         mid_in.az = side_ff[ANGLE_STAGES].dx_neg ? vai_pkg::AZ_HALF : '0;
      end else begin
         mid_in.az = az_wrapped;
      end
   end

   // inclination: clamp at zero, round half up, clamp at 90 degrees, sign by dz
   always_comb begin
      el_pos   = el_vec[ANGLE_STAGES].z[ANGLE_W-1] ? '0 : el_vec[ANGLE_STAGES].z;
      el_round = el_pos + vai_pkg::ANG_HALF;
      el_whole = el_round[ANGLE_W-1:ANG_FRAC];
      inc_mag  = (el_whole > WHOLE_W'(vai_pkg::INC_LIMIT)) ? vai_pkg::INC_LIMIT
                                                           : el_whole[INC_W-1:0];

      // no vertical part gives zero, no horizontal part gives straight up or down
      if (mid_ff[ANGLE_STAGES-1].flags.dz_zero) begin
         inc_sel = '0;
      end else if (mid_ff[ANGLE_STAGES-1].flags.flat_zero) begin
         inc_sel = vai_pkg::INC_LIMIT;
      end else begin
         inc_sel = inc_mag;
      end
      inc_out_in = mid_ff[ANGLE_STAGES-1].flags.dz_pos ? -inc_sel : inc_sel;
      az_out_in  = mid_ff[ANGLE_STAGES-1].az;
   end

   assign valid_in     = {valid_ff[PIPE_LEN-2:0], req_tvalid};
   assign rsp_valid_in = valid_ff[PIPE_LEN-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload moves with the valid bits and needs no reset
   always_ff @(posedge clock) begin
      if (advance) begin
         prep_az_ff <= prep_az_in;
         prep_dz_ff <= prep_dz_in;
         side_ff[0] <= side_in;
         for (int k = 1; k <= ANGLE_STAGES; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
         mid_ff[0] <= mid_in;
         for (int k = 1; k < ANGLE_STAGES; k++) begin
            mid_ff[k] <= mid_ff[k-1];
         end
         az_out_ff  <= az_out_in;
         inc_out_ff <= inc_out_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, inc_out_ff, az_out_ff};

   // wrap logic keeps azimuth below a full turn
   `ASSERT_ALWAYS(a_az_range, clock, reset, rsp_tvalid |-> (rsp_tdata[11:0] < vai_pkg::AZ_WRAP))
   // inclination stays within a quarter turn either way
   `ASSERT_ALWAYS(a_inc_range, clock, reset, rsp_tvalid |-> ($signed(rsp_tdata[22:12]) <= $signed(vai_pkg::INC_LIMIT) && $signed(rsp_tdata[22:12]) >= -$signed(vai_pkg::INC_LIMIT)))
   // a held result blocks new transactions
   `ASSERT_ALWAYS(a_stall_blocks, clock, reset, (rsp_tvalid && !rsp_tready) |-> !req_tready)
   // a stalled pipe keeps its occupancy
   `ASSERT_NEXT(a_stall_freezes, clock, reset, !advance, $stable(valid_ff))

endmodule

@@ tb/sv/testbench.sv @@
// testbench for view_azimuth_inclination: streamed point pairs checked against a cordic predictor
module testbench;

   localparam int COORD_W      = 24;
   localparam int STAGES       = 16;
   localparam int REQ_W        = ((6*COORD_W+7)/8)*8;
   localparam int AZ_W         = vai_pkg::AZ_W;
   localparam int INC_W        = vai_pkg::INC_W;
   // prep stage, two cordic chains, output register
   localparam int PIPE_LATENCY = 2*STAGES+2;
   // differences are lifted to a fixed magnitude before the cordic
   localparam int SCALE_SHIFT  = vai_pkg::SCALE_TOP - COORD_W;
   localparam longint ANGLE_ONE  = 65536;
   localparam longint ANGLE_HALF = 32768;
   localparam int ATAN_LEN     = 24;
   localparam int RANDOM_PAIRS = 750;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int COORD_MIN    = -(1 << (COORD_W-1));
   localparam int COORD_MAX    = (1 << (COORD_W-1)) - 1;

   // atan(2^-i) in units of 2^-16 tenth of a degree
   localparam longint ATAN_TENTHS [0:ATAN_LEN-1] = '{
      29491200, 17409672, 9198793, 4669451, 2343786, 1173036, 586661, 293348,
      146676, 73339, 36669, 18335, 9167, 4584, 2292, 1146,
      573, 286, 143, 72, 36, 18, 9, 4
   };

   typedef logic signed [COORD_W-1:0] coord_type;

   // packed so that eye_x lands in the lowest bits of req_tdata
   typedef struct packed {
      coord_type target_z;
      coord_type target_y;
      coord_type target_x;
      coord_type eye_z;
      coord_type eye_y;
      coord_type eye_x;
   } point_pair_type;

   typedef struct packed {
      logic [AZ_W-1:0]         az;
      logic signed [INC_W-1:0] inc;
   } view_angles_type;

   // handshake pressure profiles, stepped through in order
   typedef enum logic [1:0] {
      PHASE_STEADY,
      PHASE_SEND_GAPS,
      PHASE_RECV_STALLS,
      PHASE_BOTH_IDLE
   } flow_phase_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_W-1:0]          req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [vai_pkg::RSP_W-1:0] rsp_tdata;

   point_pair_type  pending_pairs[$];
   view_angles_type expected_angles[$];
   bit              req_taken = 1'b0;
   int              send_idle_pct = 0;
   int              recv_stall_pct = 0;
   int              mismatches = 0;
   int              cycle_count = 0;

   view_azimuth_inclination #(
      .COORD_BITS   (COORD_W),
      .ANGLE_STAGES (STAGES)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // vectoring cordic: drives y toward zero, leaves the gained length in x
   function automatic longint cordic_vectoring(inout longint x, input longint y);
      longint angle;
      longint xs;
      longint ys;
      angle = 0;
      for (int i = 0; i < STAGES && i < ATAN_LEN; i++) begin
         // arithmetic shift rounds toward minus infinity
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            angle = angle + ATAN_TENTHS[i];
         end else begin
            x = x - ys;
            y = y + xs;
            angle = angle - ATAN_TENTHS[i];
         end
      end
      return angle;
   endfunction

   function automatic view_angles_type predict_angles(input point_pair_type p);
      view_angles_type angles;
      longint dx, dy, dz;
      longint x, y, base, turn, horiz, slope, az, inc;
      bit     flat;
      dx = longint'(p.target_x) - longint'(p.eye_x);
      dy = longint'(p.target_y) - longint'(p.eye_y);
      dz = longint'(p.target_z) - longint'(p.eye_z);
      flat  = (dx == 0 && dy == 0);
      az    = 0;
      horiz = 0;
      if (!flat) begin
         x    = dx;
         y    = dy;
         base = 0;
         // fold the left half-plane over and add half a turn back afterwards
         if (dx < 0) begin
            x    = -dx;
            y    = -dy;
            base = 1800 * ANGLE_ONE;
         end
         x = x <<< SCALE_SHIFT;
         y = y <<< SCALE_SHIFT;
         turn  = base + cordic_vectoring(x, y);
         horiz = x;
         if (turn < 0)
            turn = turn + 3600 * ANGLE_ONE;
         az = (turn + ANGLE_HALF) / ANGLE_ONE;
         if (az >= 3600)
            az = az - 3600;
         // axis-aligned vectors are exact
         if (dx == 0)
            az = (dy > 0) ? 900 : 2700;
         else if (dy == 0)
            az = (dx > 0) ? 0 : 1800;
      end
      if (dz == 0) begin
         inc = 0;
      end else if (flat) begin
         inc = 900;
      end else begin
         // |dz| runs through an equal chain so it carries the same gain as horiz
         x = ((dz < 0) ? -dz : dz) <<< SCALE_SHIFT;
         void'(cordic_vectoring(x, 0));
         slope = cordic_vectoring(horiz, x);
         if (slope < 0)
            slope = 0;
         inc = (slope + ANGLE_HALF) / ANGLE_ONE;
         if (inc > 900)
            inc = 900;
      end
      // looking up is negative
      if (dz > 0)
         inc = -inc;
      angles.az  = az[AZ_W-1:0];
      angles.inc = inc[INC_W-1:0];
      return angles;
   endfunction

   task automatic add_pair(input int ex, input int ey, input int ez,
                           input int tx, input int ty, input int tz);
      point_pair_type p;
      p.eye_x    = coord_type'(ex);
      p.eye_y    = coord_type'(ey);
      p.eye_z    = coord_type'(ez);
      p.target_x = coord_type'(tx);
      p.target_y = coord_type'(ty);
      p.target_z = coord_type'(tz);
      pending_pairs.push_back(p);
   endtask

   function automatic coord_type extreme_coord();
      case ($urandom_range(0, 4))
         0:       return coord_type'(COORD_MIN);
         1:       return coord_type'(COORD_MAX);
         2:       return '0;
         3:       return '1;
         default: return coord_type'(1);
      endcase
   endfunction

   // geometric shapes around a random eye, with full-range noise and extreme values mixed in
   function automatic point_pair_type random_pair();
      point_pair_type p;
      int             kind;
      kind       = $urandom_range(0, 9);
      p.eye_x    = coord_type'($urandom);
      p.eye_y    = coord_type'($urandom);
      p.eye_z    = coord_type'($urandom);
      p.target_x = coord_type'($urandom);
      p.target_y = coord_type'($urandom);
      p.target_z = coord_type'($urandom);
      case (kind)
         4, 5: begin
            // short vectors: coarse angles, rounding edges
            p.target_x = coord_type'(p.eye_x + int'($urandom_range(0, 80)) - 40);
            p.target_y = coord_type'(p.eye_y + int'($urandom_range(0, 80)) - 40);
            p.target_z = coord_type'(p.eye_z + int'($urandom_range(0, 80)) - 40);
         end
         6: begin
            // medium vectors
            p.target_x = coord_type'(p.eye_x + int'($urandom_range(0, 65535)) - 32768);
            p.target_y = coord_type'(p.eye_y + int'($urandom_range(0, 65535)) - 32768);
            p.target_z = coord_type'(p.eye_z + int'($urandom_range(0, 65535)) - 32768);
         end
         7: begin
            // single-axis vector
            case ($urandom_range(0, 2))
               0: begin
                  p.target_y = p.eye_y;
                  p.target_z = p.eye_z;
               end
               1: begin
                  p.target_x = p.eye_x;
                  p.target_z = p.eye_z;
               end
               default: begin
                  p.target_x = p.eye_x;
                  p.target_y = p.eye_y;
               end
            endcase
         end
         8: begin
            // level line or vertical line
            if ($urandom_range(0, 1)) begin
               p.target_z = p.eye_z;
            end else begin
               p.target_x = p.eye_x;
               p.target_y = p.eye_y;
            end
         end
         9: begin
            p.eye_x    = extreme_coord();
            p.eye_y    = extreme_coord();
            p.eye_z    = extreme_coord();
            p.target_x = extreme_coord();
            p.target_y = extreme_coord();
            p.target_z = extreme_coord();
         end
         default: begin
         end
      endcase
      return p;
   endfunction

   // stimulus: reset, directed pairs, then random pairs under each pressure profile;
   // every profile drains fully, so the sender waits for the last result each time
   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // eye equals target, at the origin and elsewhere
      add_pair(0, 0, 0, 0, 0, 0);
      add_pair(123, -456, 789, 123, -456, 789);
      // full-range differences, on every axis and on x and y only
      add_pair(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
      add_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN);
      add_pair(COORD_MAX, COORD_MIN, 0, COORD_MIN, COORD_MAX, 0);
      // dx zero, dy of either sign
      add_pair(0, 0, 0, 0, 5000, 0);
      add_pair(0, 0, 0, 0, -5000, 300);
      // dy zero, dx of either sign
      add_pair(0, 0, 0, 7000, 0, -20);
      add_pair(0, 0, 0, -7000, 0, 0);
      // purely vertical, up and down
      add_pair(0, 0, 0, 0, 0, 100);
      add_pair(0, 0, 0, 0, 0, -100);
      add_pair(5, 5, COORD_MIN, 5, 5, COORD_MAX);
      // level line along the diagonal
      add_pair(0, 0, 0, 1000, 1000, 0);
      // unit vectors and diagonals in all quadrants
      add_pair(0, 0, 0, 1, 0, 1);
      add_pair(0, 0, 0, 1, 1, 1);
      add_pair(0, 0, 0, -1, -1, -1);
      add_pair(0, 0, 0, 1, -1, 0);
      add_pair(0, 0, 0, -1, 1, 0);
      // just below the full turn, rounds up into the wrap
      add_pair(0, 0, 0, 1000000, -1, 0);
      // all-ones eye
      add_pair(-1, -1, -1, 0, 0, 0);
      // nearly vertical and nearly level
      add_pair(0, 0, 0, 1, 0, COORD_MAX);
      add_pair(0, 0, 0, COORD_MAX, 0, 1);

      for (int ph = 0; ph < 4; ph++) begin
         case (flow_phase_type'(ph))
            PHASE_STEADY: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            PHASE_SEND_GAPS: begin
               send_idle_pct  = 77;
               recv_stall_pct = 0;
            end
            PHASE_RECV_STALLS: begin
               send_idle_pct  = 0;
               recv_stall_pct = 77;
            end
            default: begin
               send_idle_pct  = 14;
               recv_stall_pct = 14;
            end
         endcase
         for (int n = 0; n < RANDOM_PAIRS / 4; n++)
            pending_pairs.push_back(random_pair());
         while (pending_pairs.size() != 0 || expected_angles.size() != 0)
            @(posedge clock);
      end

      // let any stray result surface
      repeat (PIPE_LATENCY + 8) @(posedge clock);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // driver: new transaction or idle at the falling edge, held until taken
   always @(negedge clock) begin
      if (!reset) begin
         if (!(req_tvalid && !req_taken)) begin
            if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_pairs[0];
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // monitor: predict on each accepted request, check each accepted result
   always @(posedge clock) begin
      view_angles_type want;
      req_taken = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            req_taken = 1'b1;
            expected_angles.push_back(predict_angles(pending_pairs.pop_front()));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_angles.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result, expected none, actual az %0d inc %0d",
                        $time, rsp_tdata[AZ_W-1:0], $signed(rsp_tdata[AZ_W+INC_W-1:AZ_W]));
            end else begin
               want = expected_angles.pop_front();
               if (rsp_tdata[AZ_W-1:0] != want.az) begin
                  mismatches++;
                  $display("%0t: azimuth mismatch, expected %0d, actual %0d",
                           $time, want.az, rsp_tdata[AZ_W-1:0]);
               end
               if ($signed(rsp_tdata[AZ_W+INC_W-1:AZ_W]) != want.inc) begin
                  mismatches++;
                  $display("%0t: inclination mismatch, expected %0d, actual %0d",
                           $time, want.inc, $signed(rsp_tdata[AZ_W+INC_W-1:AZ_W]));
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

endmodule

@@ files.f @@
+incdir+rtl
rtl/vai_pkg.sv
rtl/vai_cordic_cell.sv
rtl/view_azimuth_inclination.sv
tb/sv/testbench.sv
